// ===== src/scl_pkg.sv =====
// Shared types, character codes and helper functions of the command line parser.
package scl_pkg;

  // Stored positions that a command ever looks at: 0 to 10.
  localparam int unsigned NCELLS = 11;
  localparam int unsigned NKINDS = 4;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [8*5-1:0]  TIME_STR  = "TIME=";
  localparam logic [8*6-1:0]  ARMED_STR = "ARMED=";
  localparam logic [8*10-1:0] CONN_STR  = "CONNECTED=";
  localparam logic [8*6-1:0]  ALARM_STR = "ALARM=";

  localparam logic [7:0] TIME_LEN  = 8'd11;
  localparam logic [7:0] ALARM_LEN = 8'd12;

  typedef enum logic [1:0] {
    KIND_TIME  = 2'd0,
    KIND_ALARM = 2'd1,
    KIND_ARMED = 2'd2,
    KIND_CONN  = 2'd3
  } scl_kind_e;

  // Running prefix match, one flag per command, passed from cell to cell.
  typedef struct packed {
    logic time_m;
    logic armed_m;
    logic conn_m;
    logic alarm_m;
  } scl_match_t;

  // Expected character at one position, one lane per command.
  typedef struct packed {
    logic [NKINDS-1:0]      care;
    logic [NKINDS-1:0][7:0] ch;
  } scl_pat_t;

  typedef struct packed {
    scl_kind_e  kind;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic       level;
  } scl_result_t;

  function automatic scl_pat_t pattern_at(input int unsigned pos);
    scl_pat_t p;
    p = '0;
    if (pos < 5) begin
      p.care[KIND_TIME] = 1'b1;
      p.ch[KIND_TIME]   = TIME_STR[8*(4-pos) +: 8];
    end
    if (pos < 6) begin
      p.care[KIND_ARMED] = 1'b1;
      p.ch[KIND_ARMED]   = ARMED_STR[8*(5-pos) +: 8];
      p.care[KIND_ALARM] = 1'b1;
      p.ch[KIND_ALARM]   = ALARM_STR[8*(5-pos) +: 8];
    end
    if (pos < 10) begin
      p.care[KIND_CONN] = 1'b1;
      p.ch[KIND_CONN]   = CONN_STR[8*(9-pos) +: 8];
    end
    return p;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {[8'd9:8'd13], 8'd32};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'd48:8'd57]};
  endfunction

  // atoi over two characters, wrapped to eight bits
  function automatic logic [7:0] decode_two(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    v = '0;
    if (is_ws(a)) begin
      if (is_digit(b)) v = b - CHAR_ZERO;
    end else if (a == CHAR_PLUS || a == CHAR_MINUS) begin
      if (is_digit(b)) v = b - CHAR_ZERO;
      if (a == CHAR_MINUS) v = 8'd0 - v;
    end else if (is_digit(a)) begin
      v = a - CHAR_ZERO;
      if (is_digit(b)) v = 8'(v * 8'd10) + (b - CHAR_ZERO);
    end
    return v;
  endfunction

endpackage

// ===== src/scl_cell.sv =====
// One line buffer cell: holds one character and extends the prefix match chain.
module scl_cell (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [7:0]             wr_byte_i,
  input  scl_pkg::scl_pat_t      pat_i,
  input  scl_pkg::scl_match_t    match_i,
  output scl_pkg::scl_match_t    match_o,
  output logic [7:0]             char_o
);
  import scl_pkg::*;

  logic [7:0]        char_q;
  logic [NKINDS-1:0] hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) char_q <= wr_byte_i;
  end

  // forward the byte being written so a line can end in this cycle
  assign char_o = wr_en_i ? wr_byte_i : char_q;

  always_comb begin
    for (int k = 0; k < NKINDS; k++) begin
      hit[k] = !pat_i.care[k] || (char_o == pat_i.ch[k]);
    end
  end

  assign match_o.time_m  = match_i.time_m  & hit[KIND_TIME];
  assign match_o.armed_m = match_i.armed_m & hit[KIND_ARMED];
  assign match_o.conn_m  = match_i.conn_m  & hit[KIND_CONN];
  assign match_o.alarm_m = match_i.alarm_m & hit[KIND_ALARM];

endmodule

// ===== src/scl_out_buf.sv =====
// Output register with a skid stage for result items.
module scl_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  input  scl_pkg::scl_result_t  res_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output scl_pkg::scl_result_t  out_o
);
  import scl_pkg::*;

  logic        ov_q, ov_d;
  logic        sv_q, sv_d;
  scl_result_t out_q, out_d;
  scl_result_t skid_q, skid_d;
  logic        fire;

  assign fire = ov_q & !out_stall_i;

  always_comb begin
    ov_d   = ov_q;
    sv_d   = sv_q;
    out_d  = out_q;
    skid_d = skid_q;
    if (sv_q) begin
      // input is held off while the skid stage is full
      if (fire) begin
        out_d = skid_q;
        sv_d  = 1'b0;
      end
    end else if (!ov_q || fire) begin
      ov_d  = res_valid_i;
      out_d = res_i;
    end else if (res_valid_i) begin
      skid_d = res_i;
      sv_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = sv_q;
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule

// ===== src/serial_command_line_parser_core.sv =====
// Top level of the serial command line parser: cell row, line index and result output.
//
//  channel | direction | handshake                   | payload
//  rx      | in        | rx_valid_i / rx_stall_o     | rx_byte_i
//  ev      | out       | ev_valid_o / ev_stall_i     | event_kind_o hours_o minutes_o level_o
//
// One byte is taken per cycle while rx_stall_o is low. The match over the cell row and
// the field decode settle in the cycle the newline is taken; the result is registered.
// rx_stall_o rises only when the output register and the skid stage both hold results.
// Reset clears the line index and the output valids; cell contents stay undefined.
module serial_command_line_parser_core #(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       ev_valid_o,
  input  logic       ev_stall_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] hours_o,
  output logic [7:0] minutes_o,
  output logic       level_o
);
  import scl_pkg::*;

  localparam int unsigned IW = $clog2(LINE_DEPTH + 1);

  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] len;
  logic          rx_fire, is_cr, is_lf;
  logic          full;

  scl_match_t              chain [NCELLS+1];
  logic [NCELLS-1:0][7:0]  chars;
  scl_result_t             res, out_res;
  logic                    res_valid;

  assign rx_stall_o = full;
  assign rx_fire    = rx_valid_i & !full;
  assign is_cr      = rx_byte_i == CHAR_CR;
  assign is_lf      = rx_byte_i == CHAR_LF;
  assign len        = idx_q + IW'(1);

  always_comb begin
    idx_d = idx_q;
    if (rx_fire && !is_cr) begin
      if (is_lf || len >= IW'(LINE_DEPTH)) idx_d = '0;
      else                                 idx_d = len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else         idx_q <= idx_d;
  end

  assign chain[0] = '1;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    scl_cell u_cell (
      .clk_i     (clk_i),
      .wr_en_i   (rx_fire && !is_cr && idx_q == IW'(i)),
      .wr_byte_i (rx_byte_i),
      .pat_i     (pattern_at(i)),
      .match_i   (chain[i]),
      .match_o   (chain[i+1]),
      .char_o    (chars[i])
    );
  end

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    res.kind  = KIND_TIME;
    if (rx_fire && is_lf) begin
      if (chain[NCELLS].time_m) begin
        // wrong length or missing colon: drop the line
        if (IW'(len) == IW'(TIME_LEN) && chars[7] == CHAR_COLON) begin
          res_valid   = 1'b1;
          res.kind    = KIND_TIME;
          res.hours   = decode_two(chars[5], chars[6]);
          res.minutes = decode_two(chars[8], chars[9]);
        end
      end else if (chain[NCELLS].armed_m) begin
        res_valid = 1'b1;
        res.kind  = KIND_ARMED;
        res.level = chars[6] == CHAR_ONE;
      end else if (chain[NCELLS].conn_m) begin
        res_valid = 1'b1;
        res.kind  = KIND_CONN;
        res.level = chars[10] == CHAR_ONE;
      end else if (chain[NCELLS].alarm_m) begin
        if (IW'(len) == IW'(ALARM_LEN) && chars[8] == CHAR_COLON) begin
          res_valid   = 1'b1;
          res.kind    = KIND_ALARM;
          res.hours   = decode_two(chars[6], chars[7]);
          res.minutes = decode_two(chars[9], chars[10]);
        end
      end
    end
  end

  scl_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (ev_valid_o),
    .out_stall_i (ev_stall_i),
    .out_o       (out_res)
  );

  assign event_kind_o = out_res.kind;
  assign hours_o      = out_res.hours;
  assign minutes_o    = out_res.minutes;
  assign level_o      = out_res.level;

`ifndef SYNTH
  a_skid_implies_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |-> ev_valid_o)
    else $error("skid stage full while output register empty");

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < IW'(LINE_DEPTH))
    else $error("line index beyond buffer depth");

  a_cr_holds_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && is_cr) |=> $stable(idx_q))
    else $error("carriage return moved the line index");

  a_result_on_lf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (rx_fire && is_lf))
    else $error("result raised without a newline");
`endif

endmodule
